[src/u128alu_pkg.sv]
// Shared types and constants for the 128-bit integer unit.
package u128alu_pkg;

  localparam int unsigned DataW  = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned ShiftW = 7;
  localparam int unsigned OpW    = 4;
  localparam int unsigned CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_SHL = 4'd5,
    OP_SHR = 4'd6,
    OP_AND = 4'd7,
    OP_OR  = 4'd8,
    OP_XOR = 4'd9,
    OP_NOT = 4'd10,
    OP_NEG = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ITER,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } u128alu_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic iterate;
  } u128alu_status_t;

endpackage

[src/u128alu_ctrl.sv]
// Controller state machine: sequences load, iteration and result capture.
module u128alu_ctrl
  import u128alu_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  u128alu_status_t status_i,
  output u128alu_cmd_t    cmd_o,
  output logic            busy_o
);

  state_e              state_q, state_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic                last_iter;

  assign last_iter = &cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = status_i.iterate ? ST_ITER : ST_FINISH;
      end
      ST_ITER: begin
        cnt_d = cnt_q + CountW'(1);
        if (last_iter) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_DECODE: ;
      ST_ITER:   cmd_o.step = 1'b1;
      ST_FINISH: cmd_o.capture = 1'b1;
      default: ;
    endcase
  end

  ap_load_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DECODE)
    else $error("load not followed by decode");

  ap_last_iter_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER && last_iter) |=> state_q == ST_FINISH)
    else $error("iteration did not end after full count");

  ap_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> cnt_q == '0)
    else $error("iteration count not clear in idle");

endmodule

[src/u128alu_dp.sv]
// Datapath: operand registers, shared adder, shift-add multiply and restoring divide steps.
module u128alu_dp
  import u128alu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  u128alu_cmd_t        cmd_i,
  output u128alu_status_t     status_o,
  input  logic [OpW-1:0]      op_i,
  input  logic [HalfW-1:0]    a_low_i,
  input  logic [HalfW-1:0]    a_high_i,
  input  logic [HalfW-1:0]    b_low_i,
  input  logic [HalfW-1:0]    b_high_i,
  input  logic [ShiftW-1:0]   shift_count_i,
  output logic [HalfW-1:0]    result_low_o,
  output logic [HalfW-1:0]    result_high_o,
  output logic                div_by_zero_o,
  output logic                done_o
);

  op_e                 op_q;
  logic [DataW-1:0]    a_q, a_d;       // multiplicand, or dividend shifting into quotient
  logic [DataW-1:0]    b_q, b_d;       // multiplier, or divisor
  logic [DataW-1:0]    acc_q, acc_d;   // product, or partial remainder
  logic [ShiftW-1:0]   sh_q;
  logic [DataW-1:0]    res_q, res_d;
  logic                dz_q, dz_d;
  logic                done_q;

  logic                is_div;
  logic                b_zero;
  logic [DataW:0]      add_x, add_y;
  logic                add_cin;
  logic [DataW+1:0]    sum;
  logic                take;

  assign is_div = (op_q == OP_DIV) || (op_q == OP_REM);
  assign b_zero = (b_q == '0);
  assign status_o.iterate = (op_q == OP_MUL) || (is_div && !b_zero);

  // Shared adder
  always_comb begin
    add_x   = {1'b0, a_q};
    add_y   = {1'b0, b_q};
    add_cin = 1'b0;
    unique case (op_q)
      OP_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = {1'b0, a_q};
      end
      OP_DIV, OP_REM: begin
        add_x   = {acc_q, a_q[DataW-1]};
        add_y   = ~{1'b0, b_q};
        add_cin = 1'b1;
      end
      OP_SUB: begin
        add_y   = ~{1'b0, b_q};
        add_cin = 1'b1;
      end
      OP_NEG: begin
        add_x   = {1'b0, ~a_q};
        add_y   = '0;
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum  = {1'b0, add_x} + {1'b0, add_y} + {{(DataW+1){1'b0}}, add_cin};
  // Carry out of the divide subtract means shifted remainder >= divisor
  assign take = sum[DataW+1];

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    acc_d = acc_q;
    if (cmd_i.load) begin
      a_d   = {a_high_i, a_low_i};
      b_d   = {b_high_i, b_low_i};
      acc_d = '0;
    end else if (cmd_i.step) begin
      if (is_div) begin
        a_d   = {a_q[DataW-2:0], take};
        acc_d = take ? sum[DataW-1:0] : {acc_q[DataW-2:0], a_q[DataW-1]};
      end else begin
        if (b_q[0]) acc_d = sum[DataW-1:0];
        a_d = {a_q[DataW-2:0], 1'b0};
        b_d = {1'b0, b_q[DataW-1:1]};
      end
    end
  end

  always_comb begin
    res_d = res_q;
    dz_d  = dz_q;
    if (cmd_i.capture) begin
      dz_d = is_div && b_zero;
      unique case (op_q)
        OP_ADD, OP_SUB, OP_NEG: res_d = sum[DataW-1:0];
        OP_MUL: res_d = acc_q;
        OP_DIV: res_d = b_zero ? '0 : a_q;
        OP_REM: res_d = b_zero ? '0 : acc_q;
        OP_SHL: res_d = a_q << sh_q;
        OP_SHR: res_d = a_q >> sh_q;
        OP_AND: res_d = a_q & b_q;
        OP_OR:  res_d = a_q | b_q;
        OP_XOR: res_d = a_q ^ b_q;
        OP_NOT: res_d = ~a_q;
        default: res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    res_q <= res_d;
    if (cmd_i.load) begin
      op_q <= op_e'(op_i);
      sh_q <= shift_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      dz_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.capture;
      dz_q   <= dz_d;
    end
  end

  assign result_low_o  = res_q[HalfW-1:0];
  assign result_high_o = res_q[DataW-1:HalfW];
  assign div_by_zero_o = dz_q;
  assign done_o        = done_q;

  ap_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  ap_dz_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dz_q) |-> res_q == '0)
    else $error("divide by zero with nonzero result");

  ap_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && (cmd_i.step || cmd_i.capture)))
    else $error("load overlaps step or capture");

endmodule

[src/unsigned_int128_alu_top.sv]
// Simple ops go from start through decode and capture to the registered done strobe; mul and div/rem
// run 128 iterations of the shared 130-bit adder, one bit per cycle, between decode and capture.
// Divide or remainder by zero skips the iterations.
// Throughput: one op at a time, busy_o high until capture.
// Each result is shown for one cycle on done_o and cannot be stalled by the receiver.
// Reset (rst_ni, async, active low) returns the controller to idle and clears done_o.
module unsigned_int128_alu_top
  import u128alu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OpW-1:0]      op_i,
  input  logic [HalfW-1:0]    a_low_i,
  input  logic [HalfW-1:0]    a_high_i,
  input  logic [HalfW-1:0]    b_low_i,
  input  logic [HalfW-1:0]    b_high_i,
  input  logic [ShiftW-1:0]   shift_count_i,
  output logic                done_o,
  output logic [HalfW-1:0]    result_low_o,
  output logic [HalfW-1:0]    result_high_o,
  output logic                div_by_zero_o
);

  u128alu_cmd_t    cmd;
  u128alu_status_t status;

  u128alu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  u128alu_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .op_i          (op_i),
    .a_low_i       (a_low_i),
    .a_high_i      (a_high_i),
    .b_low_i       (b_low_i),
    .b_high_i      (b_high_i),
    .shift_count_i (shift_count_i),
    .result_low_o  (result_low_o),
    .result_high_o (result_high_o),
    .div_by_zero_o (div_by_zero_o),
    .done_o        (done_o)
  );

endmodule

[test/tb.sv]
// Testbench for the 128-bit integer unit: directed and random operations checked as they finish.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u128alu_pkg::*;

  localparam int unsigned NumOps        = int'(OP_NEG) + 1;
  localparam logic [OpW-1:0] OpFirstFree = OpW'(NumOps);
  localparam logic [OpW-1:0] OpLastFree  = {OpW{1'b1}};
  localparam int unsigned DrainCycles   = 140;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [HalfW-1:0] lo;
    logic [HalfW-1:0] hi;
    logic             dz;
  } alu_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [OpW-1:0]      op_i;
  logic [HalfW-1:0]    a_low_i;
  logic [HalfW-1:0]    a_high_i;
  logic [HalfW-1:0]    b_low_i;
  logic [HalfW-1:0]    b_high_i;
  logic [ShiftW-1:0]   shift_count_i;
  logic                done_o;
  logic [HalfW-1:0]    result_low_o;
  logic [HalfW-1:0]    result_high_o;
  logic                div_by_zero_o;

  alu_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  bit          gaps_enabled   = 1'b0;

  unsigned_int128_alu_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .a_low_i       (a_low_i),
    .a_high_i      (a_high_i),
    .b_low_i       (b_low_i),
    .b_high_i      (b_high_i),
    .shift_count_i (shift_count_i),
    .done_o        (done_o),
    .result_low_o  (result_low_o),
    .result_high_o (result_high_o),
    .div_by_zero_o (div_by_zero_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic alu_result_t compute_alu_result(input logic [OpW-1:0] op,
                                                     input logic [DataW-1:0] a,
                                                     input logic [DataW-1:0] b,
                                                     input logic [ShiftW-1:0] sh);
    alu_result_t r;
    logic [DataW-1:0] v;
    v = '0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: v = a + b;
      OP_SUB: v = a - b;
      OP_MUL: v = a * b;
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else if (op == OP_DIV) begin
          v = a / b;
        end else begin
          v = a % b;
        end
      end
      OP_SHL: v = a << sh;
      OP_SHR: v = a >> sh;
      OP_AND: v = a & b;
      OP_OR:  v = a | b;
      OP_XOR: v = a ^ b;
      OP_NOT: v = ~a;
      OP_NEG: v = -a;
      default: v = '0;
    endcase
    r.op = op;
    r.lo = v[HalfW-1:0];
    r.hi = v[DataW-1:HalfW];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [OpW-1:0] op,
                                 input logic [HalfW-1:0] got, input logic [HalfW-1:0] want);
    $display("ERROR %0t: op %0d %s got %h want %h", $realtime, op, what, got, want);
    mismatch_count++;
  endtask

  // Check every strobed result against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, result_low_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_low_o !== want.lo)
          report_mismatch("result_low", want.op, result_low_o, want.lo);
        if (result_high_o !== want.hi)
          report_mismatch("result_high", want.op, result_high_o, want.hi);
        if (div_by_zero_o !== want.dz)
          report_mismatch("div_by_zero", want.op, HalfW'(div_by_zero_o), HalfW'(want.dz));
      end
    end
  end

  // Hold start until the transfer, then optionally drop it for a short burst.
  task automatic send_op(input logic [OpW-1:0] op, input logic [DataW-1:0] a,
                         input logic [DataW-1:0] b, input logic [ShiftW-1:0] sh);
    start_i       <= 1'b1;
    op_i          <= op;
    a_low_i       <= a[HalfW-1:0];
    a_high_i      <= a[DataW-1:HalfW];
    b_low_i       <= b[HalfW-1:0];
    b_high_i      <= b[DataW-1:HalfW];
    shift_count_i <= sh;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(compute_alu_result(op, a, b, sh));
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start_i       <= 1'b0;
      op_i          <= OpW'($urandom());
      a_low_i       <= {$urandom(), $urandom()};
      b_high_i      <= {$urandom(), $urandom()};
      shift_count_i <= ShiftW'($urandom());
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [HalfW-1:0] rand_half();
    logic [HalfW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = HalfW'(1) << $urandom_range(0, HalfW - 1);
      3: v = HalfW'($urandom());
      4: v = ~(HalfW'(1) << $urandom_range(0, HalfW - 1));
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  task automatic send_random_op();
    logic [OpW-1:0]   op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    int unsigned      sel;
    sel = $urandom_range(0, 49);
    op  = (sel < 48) ? OpW'(sel % NumOps) : OpW'($urandom_range(NumOps, 2**OpW - 1));
    a   = {rand_half(), rand_half()};
    b   = {rand_half(), rand_half()};
    if (op == OP_DIV || op == OP_REM) begin
      // Keep divisors small often enough that quotients are interesting.
      case ($urandom_range(0, 9))
        0: b = '0;
        1, 2, 3: b[DataW-1:HalfW] = '0;
        4, 5: b = DataW'($urandom_range(1, 1000));
        default: ;
      endcase
    end
    send_op(op, a, b, ShiftW'($urandom()));
  endtask

  task automatic test_directed_arith();
    send_op(OP_ADD, '1, 128'd1, 7'd0);
    send_op(OP_ADD, {64'd0, {HalfW{1'b1}}}, 128'd1, 7'd0);
    send_op(OP_SUB, '0, 128'd1, 7'd0);
    send_op(OP_MUL, '1, '1, 7'd0);
    send_op(OP_MUL, {rand_half(), 64'd1}, 128'd1, 7'd0);
    send_op(OP_MUL, {64'd1, 64'd0}, {64'd1, 64'd0}, 7'd0);
    send_op(OP_DIV, '1, 128'd1, 7'd0);
    send_op(OP_DIV, 128'd5, '1, 7'd0);
    // Divisor with the top bit set exercises the carry-out path of the partial remainder.
    send_op(OP_REM, '1, {64'h8000_0000_0000_0000, 64'd1}, 7'd0);
    send_op(OP_DIV, '1, '1, 7'd0);
  endtask

  task automatic test_divide_by_zero();
    send_op(OP_DIV, '1, '0, 7'd0);
    send_op(OP_REM, {rand_half(), rand_half()}, '0, 7'd5);
  endtask

  task automatic test_shift_edges();
    send_op(OP_SHL, '1, '1, 7'd0);
    send_op(OP_SHL, {rand_half(), rand_half()}, '1, 7'd64);
    send_op(OP_SHL, '1, '0, {ShiftW{1'b1}});
    send_op(OP_SHR, '1, '1, 7'd0);
    send_op(OP_SHR, {rand_half(), rand_half()}, '1, 7'd64);
    send_op(OP_SHR, '1, '0, {ShiftW{1'b1}});
  endtask

  task automatic test_logic_and_unused();
    send_op(OP_AND, '1, {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 7'd0);
    send_op(OP_OR, '0, '1, 7'd0);
    send_op(OP_XOR, '1, {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 7'd0);
    send_op(OP_NOT, '0, '1, 7'd3);
    send_op(OP_NEG, '0, '1, 7'd0);
    send_op(OpFirstFree, '1, '1, {ShiftW{1'b1}});
    send_op(OpLastFree, '1, '1, {ShiftW{1'b1}});
  endtask

  task automatic test_random_with_gaps();
    gaps_enabled = 1'b1;
    repeat (400) send_random_op();
  endtask

  task automatic test_random_streaming();
    gaps_enabled = 1'b0;
    repeat (100) send_random_op();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    op_i          <= OP_ADD;
    a_low_i       <= '0;
    a_high_i      <= '0;
    b_low_i       <= '0;
    b_high_i      <= '0;
    shift_count_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_arith();
    test_divide_by_zero();
    test_shift_edges();
    test_logic_and_unused();
    test_random_with_gaps();
    test_random_streaming();
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", '0, '0, HalfW'(pending_results.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
